### sv/mpdq_pkg.sv
// ----------------------------------------------------------------------------
// mpdq_pkg
// Shared types and constants for the mouse packet decoder and its event queue.
// ----------------------------------------------------------------------------
package mpdq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_TUSER_W = 1;

    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_DRAIN = 2'd2;

    localparam logic [7:0] HDR_ALWAYS_ONE = 8'h08;
    localparam logic [7:0] HDR_MUST_ZERO  = 8'hC0;
    localparam logic [7:0] HDR_BUTTONS    = 8'h07;

    localparam logic [31:0] START_X = 32'd400;
    localparam logic [31:0] START_Y = 32'd300;

    typedef struct packed {
        logic [2:0] buttons;
        logic [7:0] wheel;
        logic [8:0] dy;
        logic [7:0] dx;
    } ev_entry_t;

    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
        ev_entry_t        data;
    } ram_wr_t;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] queued(input logic [PTR_W-1:0] wp,
                                                input logic [PTR_W-1:0] rp);
        logic [PTR_W-1:0] r;
        r = wp - rp;
        if (wp < rp)
        begin
            r = r + PTR_W'(QUEUE_DEPTH);
        end
        return r;
    endfunction

endpackage

### sv/mpdq_event_ram.sv
// ----------------------------------------------------------------------------
// mpdq_event_ram
// Event ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mpdq_event_ram (
    input  logic                            clk,
    input  mpdq_pkg::ram_wr_t               wr,
    input  logic                            rd_en,
    input  logic [mpdq_pkg::PTR_W-1:0]      rd_addr,
    output mpdq_pkg::ev_entry_t             rd_data
);
    import mpdq_pkg::*;

    ev_entry_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/mouse_packet_decoder_queue.sv
// ----------------------------------------------------------------------------
// mouse_packet_decoder_queue
// Assembles mouse bytes into packets, queues events in a ring memory, and
// pops events or drains the queue into a wrapping cursor position.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// cfg       in         cfg_we, cfg_wdata = wheel_mode
// s_axis    in         tdata = data_byte; tuser = mode, from_aux
// m_axis    out        tdata = event and status fields; tuser = event_valid
//
// A byte word, an unused mode or a pop on an empty queue goes from idle
// straight to the emit state; a pop that returns an event passes the pop
// state first, and a drain the drain state, one ring memory read per event.
// The input accepts a new word while a finished result waits on the output.
// Reset clears the pointers, cursor and button state; the ring needs no
// clearing. A stalled output holds the block after its current word.
// ----------------------------------------------------------------------------
module mouse_packet_decoder_queue (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // data_byte[7:0]
    input  logic [mpdq_pkg::IN_TDATA_W-1:0]      s_tdata,
    // mode[1:0], from_aux[2]
    input  logic [mpdq_pkg::IN_TUSER_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // ev_dx[7:0], ev_dy[16:8], ev_wheel[24:17], ev_buttons[27:25],
    // packet_done[28], cursor_x[60:29], cursor_y[92:61], held_buttons[95:93],
    // queue_count[100:96], zero fill[103:101]
    output logic [mpdq_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // event_valid[0]
    output logic [mpdq_pkg::OUT_TUSER_W-1:0]     m_tuser
);
    import mpdq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_POP   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       byte_pos_reg, byte_pos_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [31:0]      pos_x_reg, pos_x_next;
    logic [31:0]      pos_y_reg, pos_y_next;
    logic [2:0]       held_reg, held_next;
    logic             wheel_mode_reg;
    logic             pend_reg, pend_next;
    logic             ev_valid_reg, ev_valid_next;
    ev_entry_t        ev_reg, ev_next;
    logic             done_reg, done_next;
    logic [7:0]       pkt_reg [3];
    logic             pkt_we;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [OUT_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    ram_wr_t          ram_wr;
    logic             ram_rd_en;
    logic [PTR_W-1:0] ram_rd_addr;
    ev_entry_t        ram_rd_data;

    logic             accept;
    logic             out_free;
    logic [1:0]       in_mode;
    logic             in_aux;
    logic [7:0]       in_byte;
    logic             hdr_bad;
    logic [2:0]       pkt_size;
    logic [7:0]       dy_src;
    logic [PTR_W-1:0] wr_slot_next;

    mpdq_event_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign in_mode  = s_tuser[1:0];
    assign in_aux   = s_tuser[2];
    assign in_byte  = s_tdata;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign hdr_bad  = (byte_pos_reg == 2'd0) &&
                      (((in_byte & HDR_ALWAYS_ONE) == 8'h00) ||
                       ((in_byte & HDR_MUST_ZERO) != 8'h00));
    assign pkt_size = wheel_mode_reg ? 3'd4 : 3'd3;
    assign dy_src   = (byte_pos_reg == 2'd2) ? in_byte : pkt_reg[2];
    assign wr_slot_next = next_slot(wr_ptr_reg);

    always_comb
    begin
        state_next    = state_reg;
        byte_pos_next = byte_pos_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        held_next     = held_reg;
        pend_next     = pend_reg;
        ev_valid_next = ev_valid_reg;
        ev_next       = ev_reg;
        done_next     = done_reg;
        pkt_we        = 1'b0;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ram_wr        = '0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = rd_ptr_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ev_valid_next = 1'b0;
                    ev_next       = '0;
                    done_next     = 1'b0;
                    pend_next     = 1'b0;
                    state_next    = ST_EMIT;
                    case (in_mode)
                        MODE_BYTE:
                        begin
                            if (in_aux && !hdr_bad)
                            begin
                                pkt_we = (byte_pos_reg != 2'd3);
                                if ({1'b0, byte_pos_reg} + 3'd1 < pkt_size)
                                begin
                                    byte_pos_next = byte_pos_reg + 2'd1;
                                end
                                else
                                begin
                                    byte_pos_next       = 2'd0;
                                    done_next           = 1'b1;
                                    ram_wr.en           = 1'b1;
                                    ram_wr.addr         = wr_ptr_reg;
                                    ram_wr.data.dx      = pkt_reg[1];
                                    ram_wr.data.dy      = 9'd0 - {dy_src[7], dy_src};
                                    ram_wr.data.wheel   =
                                        (wheel_mode_reg && byte_pos_reg == 2'd3)
                                        ? in_byte : 8'h00;
                                    ram_wr.data.buttons = 3'(pkt_reg[0] & HDR_BUTTONS);
                                    wr_ptr_next         = wr_slot_next;
                                    if (wr_slot_next == rd_ptr_reg)
                                    begin
                                        rd_ptr_next = next_slot(rd_ptr_reg);
                                    end
                                end
                            end
                        end
                        MODE_POP:
                        begin
                            if (rd_ptr_reg != wr_ptr_reg)
                            begin
                                ram_rd_en     = 1'b1;
                                rd_ptr_next   = next_slot(rd_ptr_reg);
                                ev_valid_next = 1'b1;
                                state_next    = ST_POP;
                            end
                        end
                        MODE_DRAIN:
                        begin
                            state_next = ST_DRAIN;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                ev_next    = ram_rd_data;
                state_next = ST_EMIT;
            end
            ST_DRAIN:
            begin
                if (pend_reg)
                begin
                    pos_x_next = pos_x_reg + {{24{ram_rd_data.dx[7]}}, ram_rd_data.dx};
                    pos_y_next = pos_y_reg + {{23{ram_rd_data.dy[8]}}, ram_rd_data.dy};
                    held_next  = ram_rd_data.buttons;
                end
                if (rd_ptr_reg != wr_ptr_reg)
                begin
                    ram_rd_en   = 1'b1;
                    rd_ptr_next = next_slot(rd_ptr_reg);
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = ev_valid_reg;
                    m_tdata_next  = {3'b000,
                                     5'(queued(wr_ptr_reg, rd_ptr_reg)),
                                     held_reg,
                                     pos_y_reg,
                                     pos_x_reg,
                                     done_reg,
                                     ev_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            byte_pos_reg   <= 2'd0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            pos_x_reg      <= START_X;
            pos_y_reg      <= START_Y;
            held_reg       <= 3'd0;
            wheel_mode_reg <= 1'b0;
            pend_reg       <= 1'b0;
            ev_valid_reg   <= 1'b0;
            done_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            byte_pos_reg <= byte_pos_next;
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            held_reg     <= held_next;
            pend_reg     <= pend_next;
            ev_valid_reg <= ev_valid_next;
            done_reg     <= done_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                wheel_mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg      <= ev_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (pkt_we)
        begin
            pkt_reg[byte_pos_reg] <= in_byte;
        end
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("accepted word did not start processing");

    a_ptrs_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !accept) |=> ($stable(rd_ptr_reg) && $stable(wr_ptr_reg)))
        else $error("queue pointers moved without a word");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result presented outside the emit state");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && state_next == ST_EMIT) |=> rd_ptr_reg == wr_ptr_reg)
        else $error("drain finished with events left in the queue");
`endif

endmodule

### test/tb_mouse_packet_decoder_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mouse_packet_decoder_queue
// Drives byte, pop, drain and unused-mode words into the mouse packet decoder
// and predicts every status word from a cycle-free model of the packet
// assembler, the overwriting event ring and the cursor. Directed words cover
// header rejection, empty-queue access and wheel mode changes inside a packet.
// A long output stall fills the queue, and random traffic with bursty input
// and a stalling output covers the rest.
// ----------------------------------------------------------------------------
module tb_mouse_packet_decoder_queue;

    import mpdq_pkg::*;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         RANDOM_PHASES = 7;
    localparam int         PHASE_WORDS   = 180;

    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_PATTERN, RX_COIN} rx_style_t;

    typedef struct packed {
        logic        valid;
        ev_entry_t   ev;
        logic        done;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [2:0]  held;
        logic [4:0]  qcount;
    } mouse_status_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic                   cfg_wdata = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [IN_TUSER_W-1:0]  s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    mouse_status_t expected_status[$];

    bit          wheel_on = 1'b0;
    logic [7:0]  pkt_bytes [0:2];
    int          byte_pos = 0;
    ev_entry_t   ring [QUEUE_DEPTH];
    int          rd_ptr = 0;
    int          wr_ptr = 0;
    logic [31:0] cur_x = START_X;
    logic [31:0] cur_y = START_Y;
    logic [2:0]  held_btn = 3'd0;

    rx_style_t   rx_style = RX_MOSTLY;
    logic [15:0] rx_pattern = 16'hB38D;
    int          hold_left = 0;
    bit          tx_steady = 1'b0;
    int          burst_left = 0;

    int cycle_count   = 0;
    int mismatches    = 0;
    int words_sent    = 0;
    int words_counted = 0;
    int results_seen  = 0;
    int packets_built = 0;
    int pops_hit      = 0;
    int drains_run    = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    mouse_packet_decoder_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always @(posedge clk)
    begin
        rx_pattern <= {rx_pattern[14:0], rx_pattern[15]};
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_style)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_MOSTLY:  m_tready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: m_tready <= rx_pattern[15];
                default:    m_tready <= 1'($urandom);
            endcase
        end
    end

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        mouse_status_t want;
        mouse_status_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got.valid  = m_tuser[0];
            got.ev     = ev_entry_t'(m_tdata[27:0]);
            got.done   = m_tdata[28];
            got.cx     = m_tdata[60:29];
            got.cy     = m_tdata[92:61];
            got.held   = m_tdata[95:93];
            got.qcount = m_tdata[100:96];
            if (expected_status.size() == 0)
            begin
                $error("result word arrived with no input word outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("event_valid", want.valid, got.valid);
                check_field("ev_dx", want.ev.dx, got.ev.dx);
                check_field("ev_dy", want.ev.dy, got.ev.dy);
                check_field("ev_wheel", want.ev.wheel, got.ev.wheel);
                check_field("ev_buttons", want.ev.buttons, got.ev.buttons);
                check_field("packet_done", want.done, got.done);
                check_field("cursor_x", want.cx, got.cx);
                check_field("cursor_y", want.cy, got.cy);
                check_field("held_buttons", want.held, got.held);
                check_field("queue_count", want.qcount, got.qcount);
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic predict_status(input logic [1:0] mode, input logic [7:0] b,
                                  input logic aux);
        mouse_status_t st;
        ev_entry_t     e;
        int            pkt_len;
        st = '0;
        pkt_len = wheel_on ? 4 : 3;
        if (mode == MODE_BYTE && aux)
        begin
            if (byte_pos != 0 || ((b & HDR_ALWAYS_ONE) != 0 && (b & HDR_MUST_ZERO) == 0))
            begin
                if (byte_pos < 3)
                begin
                    pkt_bytes[byte_pos] = b;
                end
                if (byte_pos + 1 < pkt_len)
                begin
                    byte_pos++;
                end
                else
                begin
                    e.dx      = pkt_bytes[1];
                    e.dy      = 9'd0 - {pkt_bytes[2][7], pkt_bytes[2]};
                    e.wheel   = (wheel_on && byte_pos == 3) ? b : 8'h00;
                    e.buttons = 3'(pkt_bytes[0] & HDR_BUTTONS);
                    byte_pos  = 0;
                    // A full ring drops its oldest event to make room.
                    if ((wr_ptr + 1) % QUEUE_DEPTH == rd_ptr)
                    begin
                        rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
                    end
                    ring[wr_ptr] = e;
                    wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
                    st.done = 1'b1;
                    packets_built++;
                end
            end
        end
        else if (mode == MODE_POP)
        begin
            if (rd_ptr != wr_ptr)
            begin
                st.valid = 1'b1;
                st.ev    = ring[rd_ptr];
                rd_ptr   = (rd_ptr + 1) % QUEUE_DEPTH;
                pops_hit++;
            end
        end
        else if (mode == MODE_DRAIN)
        begin
            while (rd_ptr != wr_ptr)
            begin
                e = ring[rd_ptr];
                rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
                cur_x = cur_x + {{24{e.dx[7]}}, e.dx};
                cur_y = cur_y + {{23{e.dy[8]}}, e.dy};
                held_btn = e.buttons;
            end
            drains_run++;
        end
        st.cx     = cur_x;
        st.cy     = cur_y;
        st.held   = held_btn;
        st.qcount = 5'((wr_ptr - rd_ptr + QUEUE_DEPTH) % QUEUE_DEPTH);
        expected_status.push_back(st);
    endtask

    task automatic send_word(input logic [1:0] mode, input logic [7:0] b,
                             input logic aux);
        int gap;
        if (burst_left == 0)
        begin
            if (!tx_steady)
            begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 5);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {aux, mode};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_status(mode, b, aux);
        words_sent++;
        if (mode != MODE_UNUSED && !(mode == MODE_BYTE && !aux))
        begin
            words_counted++;
        end
    endtask

    task automatic aux_byte(input logic [7:0] b);
        send_word(MODE_BYTE, b, 1'b1);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_wheel(input bit value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        wheel_on = value;
    endtask

    task automatic send_packet(input bit clean);
        logic [7:0] hdr;
        int         len;
        hdr = {2'b00, 2'($urandom), 1'b1, 3'($urandom)};
        if (!clean && $urandom_range(0, 19) == 0)
        begin
            hdr = 8'($urandom);
        end
        len = wheel_on ? 4 : 3;
        aux_byte(hdr);
        for (int i = 1; i < len; i++)
        begin
            if (!clean && $urandom_range(0, 29) == 0)
            begin
                send_word(MODE_POP, 8'($urandom), 1'($urandom));
            end
            aux_byte(8'($urandom));
        end
    endtask

    task automatic send_chunk();
        int pick;
        int cut;
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            send_packet(1'b0);
        end
        else if (pick < 77)
        begin
            send_word(MODE_POP, 8'($urandom), 1'($urandom));
        end
        else if (pick < 82)
        begin
            send_word(MODE_DRAIN, 8'($urandom), 1'($urandom));
        end
        else if (pick < 90)
        begin
            // A packet that stops early, so later bytes land out of place.
            cut = $urandom_range(0, wheel_on ? 2 : 1);
            aux_byte({2'b00, 2'($urandom), 1'b1, 3'($urandom)});
            repeat (cut) aux_byte(8'($urandom));
        end
        else
        begin
            send_word(2'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_basic_decode();
        send_word(MODE_POP, 8'h00, 1'b0);
        send_word(MODE_DRAIN, 8'hFF, 1'b1);
        send_word(MODE_UNUSED, 8'hA5, 1'b1);
        send_word(MODE_BYTE, 8'h08, 1'b0);
        aux_byte(8'h00);
        aux_byte(8'h48);
        aux_byte(8'h88);
        aux_byte(8'h08);
        aux_byte(8'h7F);
        aux_byte(8'h80);
        aux_byte(8'h3F);
        aux_byte(8'h80);
        aux_byte(8'h7F);
        send_word(MODE_POP, 8'hFF, 1'b1);
        send_word(MODE_DRAIN, 8'h00, 1'b0);
    endtask

    task automatic test_wheel_mode();
        settle();
        write_wheel(1'b1);
        aux_byte(8'h09);
        aux_byte(8'h05);
        aux_byte(8'hFB);
        aux_byte(8'h80);
        send_word(MODE_POP, 8'h00, 1'b1);
        // Wheel mode cleared after three bytes of a four-byte packet.
        aux_byte(8'h0B);
        aux_byte(8'h10);
        aux_byte(8'hF0);
        settle();
        write_wheel(1'b0);
        aux_byte(8'h55);
        // Wheel mode set after two bytes of a three-byte packet.
        aux_byte(8'h0D);
        aux_byte(8'h20);
        settle();
        write_wheel(1'b1);
        aux_byte(8'h30);
        aux_byte(8'h40);
        // Wheel mode cleared after two bytes of a four-byte packet.
        aux_byte(8'h0E);
        aux_byte(8'h22);
        settle();
        write_wheel(1'b0);
        aux_byte(8'h33);
        send_word(MODE_DRAIN, 8'h00, 1'b0);
    endtask

    task automatic test_fill_and_stall();
        settle();
        write_wheel(1'b0);
        tx_steady = 1'b1;
        hold_left = 400;
        repeat (40) send_packet(1'b1);
        repeat (33) send_word(MODE_POP, 8'($urandom), 1'($urandom));
        tx_steady = 1'b0;
        repeat (35) send_packet(1'b1);
        send_word(MODE_DRAIN, 8'h00, 1'b1);
    endtask

    task automatic test_random_traffic();
        int target;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            write_wheel(phase < 2 ? (phase == 1) : 1'($urandom));
            tx_steady = (phase == 0) || ($urandom_range(0, 3) == 0);
            rx_style  = (phase == 0) ? RX_ALWAYS : rx_style_t'($urandom_range(0, 3));
            target = words_counted + PHASE_WORDS;
            while (words_counted < target) send_chunk();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_decode();
        test_wheel_mode();
        test_fill_and_stall();
        test_random_traffic();
        settle();
        $display("Sent %0d input words (%0d acting on the decoder), checked %0d results.",
                 words_sent, words_counted, results_seen);
        $display("Queued %0d packets, %0d pops returned events, %0d drains, %0d cycles.",
                 packets_built, pops_hit, drains_run, cycle_count);
        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
